FILE: sv/assert_macros.svh
// Assertion helpers shared by the scheduler RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property that must hold in the same cycle.
`define PDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a condition in the next cycle.
`define PDS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);
`else
`define PDS_ASSERT(label, prop, msg)
`define PDS_ASSERT_NEXT(label, trig, cond, msg)
`endif
`endif

FILE: sv/pds_pkg.sv
package pds_pkg;

  localparam int TICK_W          = 32;
  localparam int KIND_W          = 3;
  localparam int TIDX_W          = 3;
  localparam int MASK_W          = 8;
  localparam int SLOT_W          = 3;
  localparam int MAX_ENTRIES_DEF = 8;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_RUN     = 3'd1,
    KIND_REG     = 3'd2,
    KIND_ENABLE  = 3'd3,
    KIND_DISABLE = 3'd4
  } kind_t;

  // Result of one entry evaluation by the shared unit
  typedef struct packed {
    logic              due;
    logic [TICK_W-1:0] adv;
  } alu_res_t;

endpackage

FILE: sv/periodic_task_due_scheduler.sv
// Channel   Handshake        Payload
// request   start / busy     in_kind, in_task_index, in_period
// result    out_valid        out_due_mask, out_status, out_slot, out_tick_now
//
// Tick, register, enable, disable: the result strobes the next cycle.
// Run scan: after the request cycle the table is read entry by entry, the shared
// compare/add evaluating each entry in the cycle after its read; once the last entry is
// evaluated, the result is posted.
// busy is high during a run scan, for all but its request cycle. Reset is synchronous,
// active low, clears tick counter, entry count and enable flags; tables need no clear.
// The receiver cannot stall: each result is present for exactly one cycle.
module periodic_task_due_scheduler #(
  parameter int MAX_ENTRIES = pds_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [pds_pkg::KIND_W-1:0]   in_kind,
  input  logic [pds_pkg::TIDX_W-1:0]   in_task_index,
  input  logic [pds_pkg::TICK_W-1:0]   in_period,
  output logic                         out_valid,
  output logic [pds_pkg::MASK_W-1:0]   out_due_mask,
  output logic                         out_status,
  output logic [pds_pkg::SLOT_W-1:0]   out_slot,
  output logic [pds_pkg::TICK_W-1:0]   out_tick_now
);
  import pds_pkg::*;
  `include "assert_macros.svh"

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t               state_r, state_nxt;
  logic [TICK_W-1:0]    tick_r, tick_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [MAX_ENTRIES-1:0] en_r, en_nxt;
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]        ev_idx_r, ev_idx_nxt;
  logic [MASK_W-1:0]    mask_r, mask_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]    out_mask_r, out_mask_nxt;
  logic                 out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [TICK_W-1:0]    out_tick_r, out_tick_nxt;

  logic                 accept;
  logic                 idx_ok;
  logic                 rd_done;
  logic                 per_we, last_we;
  logic [IW-1:0]        waddr, raddr;
  logic [TICK_W-1:0]    last_wdata;
  logic [TICK_W-1:0]    per_rdata, last_rdata;
  alu_res_t             alu_res;

  assign accept  = start && !busy;
  assign idx_ok  = ({{(32-TIDX_W){1'b0}}, in_task_index} < 32'(cnt_r));
  assign rd_done = (rd_idx_r >= cnt_r);
  assign raddr   = rd_idx_r[IW-1:0];

  pds_ram #(.WIDTH(TICK_W), .DEPTH(MAX_ENTRIES), .AW(IW)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (waddr),
    .wdata (in_period),
    .raddr (raddr),
    .rdata (per_rdata)
  );

  pds_ram #(.WIDTH(TICK_W), .DEPTH(MAX_ENTRIES), .AW(IW)) u_last_ram (
    .clk   (clk),
    .we    (last_we),
    .waddr (waddr),
    .wdata (last_wdata),
    .raddr (raddr),
    .rdata (last_rdata)
  );

  pds_alu u_alu (
    .now  (tick_r),
    .last (last_rdata),
    .per  (per_rdata),
    .res  (alu_res)
  );

  // Sequence requests and the entry scan
  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    cnt_nxt        = cnt_r;
    en_nxt         = en_r;
    rd_idx_nxt     = rd_idx_r;
    ev_vld_nxt     = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    mask_nxt       = mask_r;
    out_valid_nxt  = 1'b0;
    out_mask_nxt   = out_mask_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_tick_nxt   = out_tick_r;
    per_we         = 1'b0;
    last_we        = 1'b0;
    waddr          = ev_idx_r;
    last_wdata     = alu_res.adv;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_mask_nxt   = '0;
          out_status_nxt = 1'b0;
          out_slot_nxt   = '0;
          out_valid_nxt  = 1'b1;
          case (in_kind)
            KIND_TICK: begin
              tick_nxt = tick_r + 1'b1;
            end
            KIND_RUN: begin
              // Start the scan at entry zero
              out_valid_nxt = 1'b0;
              rd_idx_nxt    = '0;
              mask_nxt      = '0;
              state_nxt     = ST_SCAN;
            end
            KIND_REG: begin
              if ((in_period == '0) || (32'(cnt_r) >= MAX_ENTRIES)) begin
                out_status_nxt = 1'b1;
              end else begin
                waddr              = IW'(cnt_r);
                last_wdata         = tick_r;
                per_we             = 1'b1;
                last_we            = 1'b1;
                en_nxt[IW'(cnt_r)] = 1'b1;
                out_slot_nxt       = SLOT_W'(cnt_r);
                cnt_nxt            = cnt_r + 1'b1;
              end
            end
            KIND_ENABLE: begin
              if (idx_ok) begin
                waddr                      = IW'(in_task_index);
                last_wdata                 = tick_r;
                last_we                    = 1'b1;
                en_nxt[IW'(in_task_index)] = 1'b1;
              end
            end
            KIND_DISABLE: begin
              if (idx_ok) begin
                en_nxt[IW'(in_task_index)] = 1'b0;
              end
            end
            default: begin
            end
          endcase
          out_tick_nxt = tick_nxt;
        end
      end
      ST_SCAN: begin
        // Issue the next table read
        if (!rd_done) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = rd_idx_r[IW-1:0];
        end
        // Evaluate the entry read last cycle and write back its advance
        if (ev_vld_r && en_r[ev_idx_r] && alu_res.due) begin
          last_we = 1'b1;
          for (int b = 0; b < MASK_W; b++) begin
            if (32'(ev_idx_r) == b) begin
              mask_nxt[b] = 1'b1;
            end
          end
        end
        // Finish once the last entry is evaluated
        if (rd_done && !ev_vld_r) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_mask_nxt  = mask_r;
          out_tick_nxt  = tick_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      cnt_r       <= '0;
      en_r        <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      cnt_r       <= cnt_nxt;
      en_r        <= en_nxt;
      ev_vld_r    <= ev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r     <= rd_idx_nxt;
    ev_idx_r     <= ev_idx_nxt;
    mask_r       <= mask_nxt;
    out_mask_r   <= out_mask_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_tick_r   <= out_tick_nxt;
  end

  assign busy         = (state_r == ST_SCAN);
  assign out_valid    = out_valid_r;
  assign out_due_mask = out_mask_r;
  assign out_status   = out_status_r;
  assign out_slot     = out_slot_r;
  assign out_tick_now = out_tick_r;

  `PDS_ASSERT(a_no_result_in_scan, !(busy && out_valid), "result strobe during scan")
  `PDS_ASSERT(a_cnt_bound, 32'(cnt_r) <= MAX_ENTRIES, "entry count above table size")
  `PDS_ASSERT_NEXT(a_short_result, accept && (in_kind != KIND_RUN), out_valid, "no result")
  `PDS_ASSERT(a_reject_clean, !(out_valid && out_status) || ~|{out_slot, out_due_mask}, "bad reject")

endmodule

FILE: sv/pds_ram.sv
module pds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/pds_alu.sv
module pds_alu (
  input  logic [pds_pkg::TICK_W-1:0] now,
  input  logic [pds_pkg::TICK_W-1:0] last,
  input  logic [pds_pkg::TICK_W-1:0] per,
  output pds_pkg::alu_res_t          res
);
  import pds_pkg::*;

  logic [TICK_W-1:0] elapsed;

  // Wrap-safe elapsed time, due compare and advance by one period
  always_comb begin
    elapsed = now - last;
    res.due = (elapsed >= per);
    res.adv = last + per;
  end

endmodule
